FILE: rtl/tilt_fusion_balance_controller_macros.svh
// Assertion macros for the tilt fusion balance controller.
// Included by the top level; no other dependencies.
`ifndef TILT_FUSION_BALANCE_CONTROLLER_MACROS_SVH
`define TILT_FUSION_BALANCE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define TFBC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TFBC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tfbc_pkg.sv
// Shared constants and the arcsine table generator for the balance controller.
// No dependencies.
`timescale 1ns / 1ps

package tfbc_pkg;

  localparam int ACCEL_ALPHA_Q15_DEF  = 6554;
  localparam int FUSION_RATIO_Q15_DEF = 656;
  localparam int ASIN_TABLE_BITS_DEF  = 10;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 16;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIGIT_W = 4;

  localparam int DIV_N_W     = 49;
  localparam int DIV_R_W     = 21;
  localparam int MS_DIVISOR  = 1000000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GYRO_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_ZERO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KILL       = 3'd7;

  localparam int CORDIC_STEPS = 18;

  // atan(2^-i) in degrees * 65536
  function automatic longint atan_deg16(int i);
    longint r;
    case (i)
      0: r = 2949120;
      1: r = 1740967;
      2: r = 919879;
      3: r = 466945;
      4: r = 234379;
      5: r = 117304;
      6: r = 58666;
      7: r = 29335;
      8: r = 14668;
      9: r = 7334;
      10: r = 3667;
      11: r = 1833;
      12: r = 917;
      13: r = 458;
      14: r = 229;
      15: r = 115;
      16: r = 57;
      17: r = 29;
      default: r = 0;
    endcase
    return r;
  endfunction

  // arcsine of k/2^bits in Q7.8 degrees, by CORDIC vectoring
  function automatic logic [15:0] asin_entry(int bits, int k);
    longint y, x, z, n, res, bt, xs, ys;
    y = longint'(k) <<< (30 - bits);
    n = (longint'(1) <<< 60) - y * y;
    res = 0;
    for (int j = 0; j < 32; j++) begin
      bt = longint'(1) <<< (62 - 2 * j);
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >>> 1) + bt;
      end else begin
        res = res >>> 1;
      end
    end
    x = res;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_deg16(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_deg16(i);
      end
    end
    if (z < 0) z = 0;
    return 16'((z + 128) >>> 8);
  endfunction

endpackage

FILE: rtl/tfbc_sample_if.sv
// Input channel of the balance controller: one sensor word per tick.
// No dependencies.
`timescale 1ns / 1ps

interface tfbc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gyro_rate_raw;
  logic signed [15:0] accel_raw;
  logic        [15:0] elapsed_ms;

  modport source (output valid, gyro_rate_raw, accel_raw, elapsed_ms, input ready);
  modport sink (input valid, gyro_rate_raw, accel_raw, elapsed_ms, output ready);
endinterface

FILE: rtl/tfbc_result_if.sv
// Output channel of the balance controller: one drive word per tick.
// No dependencies.
`timescale 1ns / 1ps

interface tfbc_result_if;
  logic              valid;
  logic              ready;
  logic signed [8:0]  drive;
  logic signed [15:0] tilt_angle;
  logic              killed;

  modport source (output valid, drive, tilt_angle, killed, input ready);
  modport sink (input valid, drive, tilt_angle, killed, output ready);
endinterface

FILE: rtl/tfbc_mul.sv
// Radix-16 digit-serial multiplier: signed A times unsigned B, one digit a cycle.
// Depends on tfbc_pkg.
`timescale 1ns / 1ps

module tfbc_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [tfbc_pkg::MUL_A_W-1:0]  a,
  input  logic        [tfbc_pkg::MUL_B_W-1:0]  b,
  output logic                                 done,
  output logic signed [tfbc_pkg::MUL_P_W-1:0]  p
);
  import tfbc_pkg::*;

  localparam int NDIG  = MUL_B_W / DIGIT_W;
  localparam int CNT_W = $clog2(NDIG);
  localparam int PART_W = MUL_A_W + DIGIT_W + 1;

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic signed [MUL_A_W-1:0]   a_r;
  logic [MUL_B_W-1:0]          b_r;
  logic signed [MUL_P_W-1:0]   acc;
  logic signed [PART_W-1:0]    part;

  assign part = a_r * $signed({1'b0, b_r[MUL_B_W-1 -: DIGIT_W]});
  assign p    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(NDIG - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_r  <= a;
        b_r  <= b;
        acc  <= '0;
      end else if (busy) begin
        acc <= (acc <<< DIGIT_W) + MUL_P_W'(part);
        b_r <= b_r << DIGIT_W;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NDIG - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: rtl/tfbc_div.sv
// Bit-serial restoring divider of an unsigned magnitude by one million.
// Depends on tfbc_pkg.
`timescale 1ns / 1ps

module tfbc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tfbc_pkg::DIV_N_W-1:0]   n,
  output logic                           done,
  output logic [tfbc_pkg::DIV_N_W-1:0]   q
);
  import tfbc_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_N_W-1:0]   nr;
  logic [DIV_R_W-1:0]   rem;
  logic [DIV_R_W-1:0]   t;
  logic                 ge;

  assign t  = {rem[DIV_R_W-2:0], nr[DIV_N_W-1]};
  assign ge = t >= DIV_R_W'(MS_DIVISOR);
  assign q  = nr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(DIV_N_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nr   <= n;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? t - DIV_R_W'(MS_DIVISOR) : t;
        nr  <= {nr[DIV_N_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: rtl/tfbc_asin_rom.sv
// Arcsine lookup ROM, Q7.8 degrees, built at elaboration; registered read.
// Depends on tfbc_pkg.
`timescale 1ns / 1ps

module tfbc_asin_rom #(
  parameter int TABLE_BITS = tfbc_pkg::ASIN_TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [TABLE_BITS:0]   addr,
  output logic [15:0]           data
);
  import tfbc_pkg::*;

  localparam int TAB_LEN = (1 << TABLE_BITS) + 1;

  logic [15:0] tab [TAB_LEN];

  for (genvar i = 0; i < TAB_LEN; i++) begin : g_tab
    localparam logic [15:0] VAL = asin_entry(TABLE_BITS, i);
    assign tab[i] = VAL;
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end
endmodule

FILE: rtl/tilt_fusion_balance_controller.sv
// Top level of the tilt fusion balance controller: sequencer, state, config.
// Depends on tfbc_pkg, the channel interfaces, tfbc_mul, tfbc_div, tfbc_asin_rom.
`timescale 1ns / 1ps
`include "tilt_fusion_balance_controller_macros.svh"

// One sensor word in gives one drive word out. Each word runs through the accel
// filter, sine and gyro products, a 49-step bit-serial divide by one million for
// the gyro increment, then the fusion and PID products: nine products in all on
// one radix-16 digit-serial multiplier, four digits each. The output register is
// then loaded, which waits while an unread result still holds it. One word is in
// flight at a time; a finished result sits in the output register, so the
// next word is accepted while it waits. Configuration writes take effect on the
// next word and must be made while no word is in flight.
module tilt_fusion_balance_controller #(
  parameter int ACCEL_ALPHA_Q15  = tfbc_pkg::ACCEL_ALPHA_Q15_DEF,
  parameter int FUSION_RATIO_Q15 = tfbc_pkg::FUSION_RATIO_Q15_DEF,
  parameter int ASIN_TABLE_BITS  = tfbc_pkg::ASIN_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  tfbc_sample_if.sink                       sample,
  tfbc_result_if.source                     result,
  input  logic                              wr_en,
  input  logic [tfbc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [tfbc_pkg::CFG_DATA_W-1:0]   wr_data
);
  import tfbc_pkg::*;

  localparam int K_W = ASIN_TABLE_BITS + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FILT = 4'd1;
  localparam logic [3:0] ST_SIN  = 4'd2;
  localparam logic [3:0] ST_GYR1 = 4'd3;
  localparam logic [3:0] ST_GYR2 = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_FUS1 = 4'd6;
  localparam logic [3:0] ST_FUS2 = 4'd7;
  localparam logic [3:0] ST_PROP = 4'd8;
  localparam logic [3:0] ST_DERV = 4'd9;
  localparam logic [3:0] ST_INTG = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [34:0] v);
    if (v > 35'sd32767) return 16'sh7FFF;
    if (v < -35'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // configuration
  logic signed [15:0] gyro_zero, acc_zero;
  logic [15:0]        gyro_scale, acc_scale, gain_p, gain_i, gain_d;
  logic [14:0]        kill_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_zero  <= '0;
      gyro_scale <= '0;
      acc_zero   <= '0;
      acc_scale  <= 16'd4;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      kill_angle <= 15'd11520;
    end else if (wr_en) begin
      case (wr_index)
        REG_GYRO_ZERO:  gyro_zero  <= wr_data;
        REG_GYRO_SCALE: gyro_scale <= wr_data;
        REG_ACC_ZERO:   acc_zero   <= wr_data;
        REG_ACC_SCALE:  acc_scale  <= wr_data;
        REG_GAIN_P:     gain_p     <= wr_data;
        REG_GAIN_I:     gain_i     <= wr_data;
        REG_GAIN_D:     gain_d     <= wr_data;
        REG_KILL:       kill_angle <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  logic [3:0]                state;
  logic                      mul_phase, div_phase;
  logic signed [15:0]        gyro_r, accel_r;
  logic [15:0]               ms_r;
  logic signed [31:0]        af, isum, g_val;
  logic signed [15:0]        ang_now, ang_prev;
  logic signed [MUL_A_W-1:0] gprod;
  logic signed [MUL_P_W-1:0] f1;
  logic signed [32:0]        p_r, d_r;
  logic                      s_neg, g_neg;
  logic [K_W-1:0]            k_reg;
  logic [DIV_N_W-1:0]        div_n;

  logic                      mul_start, mul_done, div_start, div_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [DIV_N_W-1:0]        div_q;
  logic [15:0]               rom_q;

  logic                      res_valid;
  logic signed [8:0]         res_drive;
  logic signed [15:0]        res_angle;
  logic                      res_killed;

  tfbc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  tfbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .done  (div_done),
    .q     (div_q)
  );

  tfbc_asin_rom #(.TABLE_BITS(ASIN_TABLE_BITS)) u_rom (
    .clk  (clk),
    .addr (k_reg),
    .data (rom_q)
  );

  logic is_mul_st;
  assign is_mul_st = (state inside {ST_FILT, ST_SIN, ST_GYR1, ST_GYR2, ST_FUS1, ST_FUS2,
                                    ST_PROP, ST_DERV, ST_INTG});
  assign mul_start = is_mul_st && !mul_phase;
  assign div_start = (state == ST_DIV) && !div_phase;

  logic signed [16:0] acc_ang;
  assign acc_ang = s_neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FILT: begin
        mul_a = (MUL_A_W'(accel_r) <<< 15) - MUL_A_W'(af);
        mul_b = MUL_B_W'(ACCEL_ALPHA_Q15);
      end
      ST_SIN: begin
        mul_a = MUL_A_W'(af) + (MUL_A_W'(acc_zero) <<< 15);
        mul_b = acc_scale;
      end
      ST_GYR1: begin
        mul_a = MUL_A_W'(gyro_r) - MUL_A_W'(gyro_zero);
        mul_b = gyro_scale;
      end
      ST_GYR2: begin
        mul_a = gprod;
        mul_b = ms_r;
      end
      ST_FUS1: begin
        mul_a = MUL_A_W'(ang_now) + MUL_A_W'(g_val);
        mul_b = MUL_B_W'(32768 - FUSION_RATIO_Q15);
      end
      ST_FUS2: begin
        mul_a = MUL_A_W'(acc_ang);
        mul_b = MUL_B_W'(FUSION_RATIO_Q15);
      end
      ST_PROP: begin
        mul_a = MUL_A_W'(ang_now);
        mul_b = gain_p;
      end
      ST_DERV: begin
        mul_a = MUL_A_W'(ang_now) - MUL_A_W'(ang_prev);
        mul_b = gain_d;
      end
      ST_INTG: begin
        mul_a = MUL_A_W'(ang_now);
        mul_b = gain_i;
      end
      default: ;
    endcase
  end

  // sine magnitude and table index
  logic [MUL_P_W-1:0] s_abs;
  logic [32:0]        s_mag;
  logic [K_W-1:0]     k_calc;
  always_comb begin
    s_abs = mul_p[MUL_P_W-1] ? MUL_P_W'(-mul_p) : MUL_P_W'(mul_p);
    s_mag = (s_abs > (MUL_P_W'(1) << 31)) ? (33'd1 << 31) : s_abs[32:0];
    k_calc = K_W'((s_mag + (33'd1 << (30 - ASIN_TABLE_BITS))) >> (31 - ASIN_TABLE_BITS));
  end

  logic signed [MUL_P_W-1:0] fused;
  logic signed [MUL_P_W-1:0] fused_sh;
  assign fused    = f1 + mul_p + MUL_P_W'(16384);
  assign fused_sh = fused >>> 15;

  // drive from the PID sum
  logic signed [34:0] total;
  logic signed [18:0] tq;
  logic signed [8:0]  drive_c;
  logic [16:0]        ang_mag;
  logic               kill_c;
  always_comb begin
    total = 35'(p_r) + 35'(d_r) + 35'(isum);
    tq    = 19'(total >>> 16);
    if (total[34] && (total[15:0] != 16'd0)) tq = tq + 19'sd1;
    if (tq > 19'sd255) drive_c = 9'sd255;
    else if (tq < -19'sd255) drive_c = -9'sd255;
    else drive_c = tq[8:0];
    ang_mag = ang_now[15] ? 17'(-(17'(ang_now))) : 17'(ang_now);
    kill_c  = ang_mag >= 17'(kill_angle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_phase <= 1'b0;
      div_phase <= 1'b0;
      af        <= '0;
      ang_now   <= '0;
      ang_prev  <= '0;
      isum      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready && state != ST_DONE) res_valid <= 1'b0;
      if (mul_start) mul_phase <= 1'b1;
      if (mul_done) mul_phase <= 1'b0;
      if (div_start) div_phase <= 1'b1;
      if (div_done) div_phase <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            gyro_r  <= sample.gyro_rate_raw;
            accel_r <= sample.accel_raw;
            ms_r    <= sample.elapsed_ms;
            state   <= ST_FILT;
          end
        end
        ST_FILT: if (mul_done) begin
          af    <= sat32(34'(af) + 34'(mul_p >>> 15));
          state <= ST_SIN;
        end
        ST_SIN: if (mul_done) begin
          s_neg <= mul_p[MUL_P_W-1];
          k_reg <= k_calc;
          state <= ST_GYR1;
        end
        ST_GYR1: if (mul_done) begin
          gprod <= mul_p[MUL_A_W-1:0];
          state <= ST_GYR2;
        end
        ST_GYR2: if (mul_done) begin
          g_neg <= mul_p[MUL_P_W-1];
          div_n <= mul_p[MUL_P_W-1] ? DIV_N_W'(-mul_p) : DIV_N_W'(mul_p);
          state <= ST_DIV;
        end
        ST_DIV: if (div_done) begin
          g_val <= g_neg ? -(32'(div_q)) : 32'(div_q);
          state <= ST_FUS1;
        end
        ST_FUS1: if (mul_done) begin
          f1    <= mul_p;
          state <= ST_FUS2;
        end
        ST_FUS2: if (mul_done) begin
          ang_prev <= ang_now;
          ang_now  <= sat16(35'(fused_sh));
          state    <= ST_PROP;
        end
        ST_PROP: if (mul_done) begin
          p_r   <= mul_p[32:0];
          state <= ST_DERV;
        end
        ST_DERV: if (mul_done) begin
          d_r   <= mul_p[32:0];
          state <= ST_INTG;
        end
        ST_INTG: if (mul_done) begin
          isum  <= sat32(34'(isum) + 34'($signed(mul_p[32:0])));
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid  <= 1'b1;
            res_drive  <= kill_c ? 9'sd0 : drive_c;
            res_angle  <= ang_now;
            res_killed <= kill_c;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign sample.ready      = (state == ST_IDLE);
  assign result.valid      = res_valid;
  assign result.drive      = res_drive;
  assign result.tilt_angle = res_angle;
  assign result.killed     = res_killed;

  `TFBC_ASSERT_IMP(a_kill_zero, clk, rst, result.valid && result.killed, result.drive == 9'sd0, "killed word carries drive")
  `TFBC_ASSERT_NXT(a_accept_busy, clk, rst, sample.valid && sample.ready, state == ST_FILT, "sequencer did not start")
  `TFBC_ASSERT_IMP(a_mul_req, clk, rst, mul_done, mul_phase, "multiplier done without request")
endmodule

FILE: tb/tfbc_balance_checker.sv
// Checker for the tilt fusion balance controller: keeps its own model of the
// filter, fusion and PID state, and checks each drive word against it.
// Depends on tfbc_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module tfbc_balance_checker (
  input  logic                            clk,
  input  logic                            rst,
  tfbc_sample_if                          sample,
  tfbc_result_if                          result,
  input  logic                            wr_en,
  input  logic [tfbc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [tfbc_pkg::CFG_DATA_W-1:0] wr_data,
  output int                              errors,
  output int                              pending,
  output int                              words_checked,
  output int                              kills_seen
);
  import tfbc_pkg::*;

  localparam int TBITS   = ASIN_TABLE_BITS_DEF;
  localparam int TLEN    = (1 << TBITS) + 1;
  localparam longint ALPHA = ACCEL_ALPHA_Q15_DEF;
  localparam longint FRAT  = FUSION_RATIO_Q15_DEF;

  typedef struct packed {
    logic signed [8:0]  drive;
    logic signed [15:0] tilt_angle;
    logic               killed;
  } drive_word_t;

  localparam longint ATAN_DEG16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  longint tilt_lut [TLEN];

  logic signed [15:0] gyro_bias, accel_bias;
  logic        [15:0] gyro_gain, accel_gain, kp, ki, kd;
  logic        [14:0] kill_limit;
  longint             accel_lp, integ;
  logic signed [15:0] ang_now, ang_old;

  drive_word_t expected_words [$];

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  initial begin
    longint y, x, z, xs, ys;
    for (int k = 0; k < TLEN; k++) begin
      y = longint'(k) <<< (30 - TBITS);
      x = root_floor((64'd1 << 60) - y * y);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_DEG16[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_DEG16[i];
        end
      end
      if (z < 0) z = 0;
      tilt_lut[k] = (z + 128) >>> 8;
    end
  end

  function automatic drive_word_t balance_tick(longint gyro, longint accel, longint ms);
    longint s, mag, k, acc_ang, g, fused, p, d, total, drv, amag;
    drive_word_t w;
    accel_lp = clampl(accel_lp + ((accel * 32768 - accel_lp) * ALPHA >>> 15),
                      -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    s = (accel_lp + longint'(accel_bias) * 32768) * longint'(accel_gain);
    s = clampl(s, -(64'sd1 <<< 31), 64'sd1 <<< 31);
    mag = s < 0 ? -s : s;
    k = (mag + (64'sd1 <<< (30 - TBITS))) >>> (31 - TBITS);
    if (k > TLEN - 1) k = TLEN - 1;
    acc_ang = s < 0 ? -tilt_lut[k] : tilt_lut[k];
    g = (gyro - longint'(gyro_bias)) * longint'(gyro_gain) * ms / 1000000;
    fused = (32768 - FRAT) * (longint'(ang_now) + g) + FRAT * acc_ang + 16384;
    ang_old = ang_now;
    ang_now = 16'(clampl(fused >>> 15, -32768, 32767));
    p = longint'(ang_now) * longint'(kp);
    d = (longint'(ang_now) - longint'(ang_old)) * longint'(kd);
    integ = clampl(integ + longint'(ang_now) * longint'(ki),
                   -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    total = p + d + integ;
    drv = clampl(total / 65536, -255, 255);
    amag = ang_now < 0 ? -longint'(ang_now) : longint'(ang_now);
    w.killed = amag >= longint'(kill_limit);
    if (w.killed) drv = 0;
    w.drive = 9'(drv);
    w.tilt_angle = ang_now;
    return w;
  endfunction

  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      gyro_bias <= 0; gyro_gain <= 0; accel_bias <= 0; accel_gain <= 16'd4;
      kp <= 0; ki <= 0; kd <= 0; kill_limit <= 15'd11520;
      accel_lp = 0; integ = 0; ang_now = 0; ang_old = 0;
      expected_words.delete();
      errors <= 0; words_checked <= 0; kills_seen <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_GYRO_ZERO:  gyro_bias  <= wr_data;
          REG_GYRO_SCALE: gyro_gain  <= wr_data;
          REG_ACC_ZERO:   accel_bias <= wr_data;
          REG_ACC_SCALE:  accel_gain <= wr_data;
          REG_GAIN_P:     kp         <= wr_data;
          REG_GAIN_I:     ki         <= wr_data;
          REG_GAIN_D:     kd         <= wr_data;
          REG_KILL:       kill_limit <= wr_data[14:0];
          default: ;
        endcase
      end
      if (sample.valid && sample.ready)
        expected_words.push_back(balance_tick(longint'(sample.gyro_rate_raw),
          longint'(sample.accel_raw), longint'(sample.elapsed_ms)));
      if (result.valid && result.ready) begin
        words_checked <= words_checked + 1;
        if (result.killed) kills_seen <= kills_seen + 1;
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("mismatch: unexpected drive word at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = expected_words.pop_front();
          if (result.drive !== want.drive || result.tilt_angle !== want.tilt_angle ||
              result.killed !== want.killed) begin
            if (errors < 10)
              $display("mismatch: drive %0d/%0d angle %0d/%0d killed %0b/%0b (exp/act)",
                       want.drive, result.drive, want.tilt_angle, result.tilt_angle,
                       want.killed, result.killed);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_words.size();

endmodule

FILE: tb/tb.sv
// Testbench top for the tilt fusion balance controller: clock, reset, register
// setup, sensor words and result back-pressure; tfbc_balance_checker checks.
// Depends on tfbc_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module tb;
  import tfbc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  int errors, pending, words_checked, kills_seen;
  int hold_len = 0;
  bit idle_on = 1'b1;
  int cycles = 0;

  tfbc_sample_if sample ();
  tfbc_result_if result ();

  tilt_fusion_balance_controller DUT (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data));

  tfbc_balance_checker checker_i (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .pending(pending), .words_checked(words_checked),
    .kills_seen(kills_seen));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sample.valid = 1'b0;
    sample.gyro_rate_raw = '0;
    sample.accel_raw = '0;
    sample.elapsed_ms = '0;
    result.ready = 1'b0;
  end

  // result back-pressure
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        result.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result.ready = 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end else begin
        result.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // ready only moves at the rising edge, so its value at the falling edge
  // is the one the next rising edge sees
  task automatic send_word(input logic [15:0] g, input logic [15:0] a,
                           input logic [15:0] ms);
    int n;
    sample.valid = 1'b1;
    sample.gyro_rate_raw = g;
    sample.accel_raw = a;
    sample.elapsed_ms = ms;
    while (!sample.ready) @(negedge clk);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      sample.valid = 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    sample.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] gz, gs, az, as, gp, gi, gd, kill);
    drain();
    write_reg(REG_GYRO_ZERO, gz);
    write_reg(REG_GYRO_SCALE, gs);
    write_reg(REG_ACC_ZERO, az);
    write_reg(REG_ACC_SCALE, as);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_KILL, kill);
  endtask

  // mostly a smooth tilt trace with noise, sometimes raw noise
  task automatic random_run(input int count);
    int accel, gyro, step_ms;
    accel = $urandom_range(0, 8000) - 4000;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        accel = accel + $urandom_range(0, 800) - 400;
        if (accel > 32767) accel = 32767;
        if (accel < -32768) accel = -32768;
        gyro = $urandom_range(0, 4000) - 2000;
        step_ms = $urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 40);
        send_word(16'(gyro), 16'(accel), 16'(step_ms));
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // reset values: gyro gain zero, zero-time and extreme accel words
    send_word(16'h0000, 16'h0000, 16'd0);
    send_word(16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_word(16'h8000, 16'h8000, 16'd0);
    send_word(16'h8000, 16'h7FFF, 16'd10);

    // all registers at their top end: gyro saturates angle, integral overflows
    set_regs(16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'h7FFF);
    send_word(16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_word(16'h7FFF, 16'h8000, 16'hFFFF);
    send_word(16'h8000, 16'h8000, 16'hFFFF);
    send_word(16'h8000, 16'h0000, 16'd0);
    send_word(16'h0000, 16'h8000, 16'd1);
    send_word(16'h5555, 16'hAAAA, 16'h5555);

    // kill limit zero: every word is killed; other extremes low
    set_regs(16'h7FFF, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(16'h1234, 16'h8000, 16'd5);
    send_word(16'hAAAA, 16'h7FFF, 16'd5);
    send_word(16'h0000, 16'h0000, 16'd0);

    // moderate gains, accel beyond full scale clamps to ninety degrees
    set_regs(16'd0, 16'd5000, 16'd0, 16'd200, 16'd2000, 16'd30, 16'd500, 16'd11520);
    send_word(16'd0, 16'h7FFF, 16'd10);
    send_word(16'd0, 16'h7FFF, 16'd10);
    send_word(16'd300, 16'h8000, 16'd10);
    send_word(16'hFF00, 16'd100, 16'd0);
    send_word(16'd1000, 16'd0, 16'd20);

    for (int ph = 0; ph < 4; ph++) begin
      set_regs(16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 40000)),
               16'($urandom_range(0, 400) - 200), 16'($urandom_range(1, 12)),
               16'($urandom_range(0, 8000)), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 4000)),
               16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767) :
                   $urandom_range(2000, 11520)));
      if (ph == 1) begin
        // long output stall while words keep coming
        sample.valid = 1'b0;
        @(negedge clk);
        hold_len = 600;
      end
      if (ph == 3) idle_on = 1'b0;
      random_run(ph == 0 ? 100 : 110);
    end

    drain();
    repeat (200) @(negedge clk);
    $display("checked %0d drive words (%0d killed) over reset, extreme and random",
             words_checked, kills_seen);
    $display("register settings, with output stalls and input gaps");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
